>>> rtl/pme_pkg.sv
// Package for the pheromone matrix engine: word types, op codes, config
// register indexes, sizes and helpers. No dependencies.
`default_nettype none
package pme_pkg;

	localparam int MAX_NODES = 64;
	localparam int NODE_W    = $clog2(MAX_NODES);
	localparam int CELL_W    = 2 * NODE_W;
	localparam int CNT_W     = NODE_W + 1;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DW    = 32;

	localparam logic [16:0] DECAY_RST = 17'd58982;
	localparam logic [31:0] INIT_RST  = 32'd65536;
	localparam logic [CNT_W-1:0] NODES_RST = CNT_W'(MAX_NODES);
	localparam logic [31:0] TOP32 = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		MODE_DEPOSIT = 2'd0,
		MODE_EVAP    = 2'd1,
		MODE_READ    = 2'd2,
		MODE_REINIT  = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DECAY      = 2'd0,
		REG_INIT_LEVEL = 2'd1,
		REG_NODE_COUNT = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [5:0]  node_from;
		logic [5:0]  node_to;
		logic [23:0] tour_length;
		logic [31:0] deposit_scale;
	} in_word_t;

	typedef struct packed {
		logic [31:0] level;
		logic        saturated;
	} out_word_t;

	typedef struct packed {
		logic [16:0]      decay;
		logic [31:0]      initial_level;
		logic [CNT_W-1:0] node_count;
	} cfg_t;

	typedef struct packed {
		mode_t             op;
		logic              in_range;
		logic [NODE_W-1:0] a;
		logic [NODE_W-1:0] b;
		logic [23:0]       len;
		logic [31:0]       q;
	} cmd_t;

	typedef struct packed {
		logic clearing;
	} bk_status_t;

	function automatic logic [CNT_W-1:0] active_nodes(input logic [CNT_W-1:0] n);
		active_nodes = (n > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : n;
	endfunction

endpackage
`default_nettype wire

>>> rtl/pme_cfg.sv
// Configuration registers of the pheromone matrix engine.
// Depends on pme_pkg.
`default_nettype none
module pme_cfg (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [pme_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [pme_pkg::CFG_DW-1:0]    cfg_data,
	output pme_pkg::cfg_t                      cfg
);
	import pme_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.decay         <= DECAY_RST;
			cfg_q.initial_level <= INIT_RST;
			cfg_q.node_count    <= NODES_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_DECAY:      cfg_q.decay         <= cfg_data[16:0];
				REG_INIT_LEVEL: cfg_q.initial_level <= cfg_data[31:0];
				REG_NODE_COUNT: cfg_q.node_count    <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

>>> rtl/pme_front.sv
// Front end: takes input words, decodes mode and node range, and queues
// commands for the back end in a two-entry queue. Depends on pme_pkg.
`default_nettype none
module pme_front (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  pme_pkg::in_word_t item,
	input  pme_pkg::cfg_t    cfg,
	input  pme_pkg::bk_status_t bk_status,
	output logic             cmd_valid,
	output pme_pkg::cmd_t    cmd,
	input  wire logic        cmd_take
);
	import pme_pkg::*;

	cmd_t       ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic [CNT_W-1:0] nn;
	cmd_t       new_cmd;
	logic       do_push;
	logic       do_pop;

	always_comb begin
		nn               = active_nodes(cfg.node_count);
		new_cmd.op       = mode_t'(item.mode);
		new_cmd.a        = item.node_from;
		new_cmd.b        = item.node_to;
		new_cmd.len      = item.tour_length;
		new_cmd.q        = item.deposit_scale;
		new_cmd.in_range = ({1'b0, item.node_from} < nn) && ({1'b0, item.node_to} < nn);
	end

	assign full      = (count_q == 2'd2) || bk_status.clearing;
	assign do_push   = push && !full;
	assign cmd_valid = (count_q != 2'd0);
	assign do_pop    = cmd_take && cmd_valid;
	assign cmd       = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			ent_q[wr_ptr_q] <= new_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push)
				wr_ptr_q <= !wr_ptr_q;
			if (do_pop)
				rd_ptr_q <= !rd_ptr_q;
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> rtl/pme_back.sv
// Back end: level and pending memories, bit-serial divider, sweep and fill
// sequencer, and the result register. Depends on pme_pkg.
`default_nettype none
module pme_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  pme_pkg::cfg_t      cfg,
	input  wire logic          cmd_valid,
	input  pme_pkg::cmd_t      cmd,
	output logic               cmd_take,
	output pme_pkg::bk_status_t bk_status,
	output logic               empty,
	input  wire logic          pop,
	output pme_pkg::out_word_t result
);
	import pme_pkg::*;

	localparam int CELLS = MAX_NODES * MAX_NODES;

	typedef enum logic [3:0] {
		ST_FILL,
		ST_IDLE,
		ST_DIV,
		ST_DIV_END,
		ST_DEP_RD,
		ST_DEP_WR,
		ST_EV_RD,
		ST_EV_MUL,
		ST_EV_WR,
		ST_RD,
		ST_RD_OUT
	} state_t;

	logic [31:0] level_mem [CELLS];
	logic [31:0] pend_mem  [CELLS];

	state_t            state_q;
	cmd_t              cmd_q;
	logic [CELL_W-1:0] addr_q;
	logic [31:0]       level_rd_q;
	logic [31:0]       pend_rd_q;
	logic [31:0]       fill_q;
	logic              report_q;
	logic [24:0]       rem_q;
	logic [47:0]       quo_q;
	logic [5:0]        cnt_q;
	logic [31:0]       amount_q;
	logic              sat_q;
	logic              second_q;
	logic [48:0]       prod_q;
	logic [31:0]       max_q;
	logic [NODE_W-1:0] nn_m1_q;
	out_word_t         res_q;
	logic              res_valid_q;

	logic [CNT_W-1:0]  nn;
	logic [24:0]       trial;
	logic              ge;
	logic [32:0]       kept;
	logic [31:0]       kept_c;
	logic [32:0]       ev_sum;
	logic [31:0]       ev_v;
	logic              ev_sat;
	logic [31:0]       mx_next;
	logic [32:0]       dep_sum;
	logic [31:0]       dep_v;
	logic              lvl_we;
	logic              pnd_we;
	logic [31:0]       lvl_wdata;
	logic [31:0]       pnd_wdata;
	logic [NODE_W-1:0] row;
	logic [NODE_W-1:0] col;

	always_comb begin
		nn      = active_nodes(cfg.node_count);
		trial   = {rem_q[23:0], quo_q[47]};
		ge      = trial >= {1'b0, cmd_q.len};
		kept    = prod_q[48:16];
		kept_c  = kept[32] ? TOP32 : kept[31:0];
		ev_sum  = {1'b0, kept_c} + {1'b0, pend_rd_q};
		ev_v    = ev_sum[32] ? TOP32 : ev_sum[31:0];
		ev_sat  = kept[32] | ev_sum[32];
		mx_next = (ev_v > max_q) ? ev_v : max_q;
		dep_sum = {1'b0, pend_rd_q} + {1'b0, amount_q};
		dep_v   = dep_sum[32] ? TOP32 : dep_sum[31:0];
		row     = addr_q[CELL_W-1:NODE_W];
		col     = addr_q[NODE_W-1:0];
		lvl_we    = (state_q == ST_EV_WR) || (state_q == ST_FILL);
		lvl_wdata = (state_q == ST_FILL) ? fill_q : ev_v;
		pnd_we    = lvl_we || (state_q == ST_DEP_WR);
		pnd_wdata = (state_q == ST_DEP_WR) ? dep_v : 32'd0;
	end

	always_ff @(posedge clk) begin
		if (lvl_we)
			level_mem[addr_q] <= lvl_wdata;
		if (pnd_we)
			pend_mem[addr_q] <= pnd_wdata;
		level_rd_q <= level_mem[addr_q];
		pend_rd_q  <= pend_mem[addr_q];
	end

	assign cmd_take           = (state_q == ST_IDLE) && cmd_valid && !res_valid_q;
	assign bk_status.clearing = (state_q == ST_FILL) && !report_q;
	assign empty              = !res_valid_q;
	assign result             = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_FILL;
			addr_q      <= '0;
			fill_q      <= INIT_RST;
			report_q    <= 1'b0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
			cmd_q       <= '0;
			rem_q       <= '0;
			quo_q       <= '0;
			cnt_q       <= '0;
			amount_q    <= '0;
			sat_q       <= 1'b0;
			second_q    <= 1'b0;
			prod_q      <= '0;
			max_q       <= '0;
			nn_m1_q     <= '0;
		end else begin
			if (pop && res_valid_q)
				res_valid_q <= 1'b0;
			case (state_q)
				ST_FILL: begin
					if (addr_q == '1) begin
						if (report_q) begin
							res_q       <= '{level: fill_q, saturated: 1'b0};
							res_valid_q <= 1'b1;
						end
						state_q <= ST_IDLE;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (cmd_take) begin
						cmd_q    <= cmd;
						sat_q    <= 1'b0;
						second_q <= 1'b0;
						case (cmd.op)
							MODE_DEPOSIT: begin
								if (!cmd.in_range) begin
									res_q       <= '0;
									res_valid_q <= 1'b1;
								end else if (cmd.len == '0) begin
									amount_q <= TOP32;
									sat_q    <= 1'b1;
									addr_q   <= {cmd.a, cmd.b};
									state_q  <= ST_DEP_RD;
								end else begin
									rem_q   <= '0;
									quo_q   <= {cmd.q, 16'd0};
									cnt_q   <= '0;
									state_q <= ST_DIV;
								end
							end
							MODE_EVAP: begin
								max_q <= '0;
								if (nn == '0) begin
									res_q       <= '0;
									res_valid_q <= 1'b1;
								end else begin
									nn_m1_q <= NODE_W'(nn - 1'b1);
									addr_q  <= '0;
									state_q <= ST_EV_RD;
								end
							end
							MODE_READ: begin
								if (!cmd.in_range) begin
									res_q       <= '0;
									res_valid_q <= 1'b1;
								end else begin
									addr_q  <= {cmd.a, cmd.b};
									state_q <= ST_RD;
								end
							end
							MODE_REINIT: begin
								fill_q   <= cfg.initial_level;
								report_q <= 1'b1;
								addr_q   <= '0;
								state_q  <= ST_FILL;
							end
							default: ;
						endcase
					end
				end
				ST_DIV: begin
					rem_q <= ge ? (trial - {1'b0, cmd_q.len}) : trial;
					quo_q <= {quo_q[46:0], ge};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 6'd47)
						state_q <= ST_DIV_END;
				end
				ST_DIV_END: begin
					if (quo_q[47:32] != '0) begin
						amount_q <= TOP32;
						sat_q    <= 1'b1;
					end else begin
						amount_q <= quo_q[31:0];
					end
					addr_q  <= {cmd_q.a, cmd_q.b};
					state_q <= ST_DEP_RD;
				end
				ST_DEP_RD: state_q <= ST_DEP_WR;
				ST_DEP_WR: begin
					if (!second_q) begin
						sat_q    <= sat_q | dep_sum[32];
						second_q <= 1'b1;
						addr_q   <= {cmd_q.b, cmd_q.a};
						state_q  <= ST_DEP_RD;
					end else begin
						res_q       <= '{level: amount_q, saturated: sat_q | dep_sum[32]};
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				ST_EV_RD: state_q <= ST_EV_MUL;
				ST_EV_MUL: begin
					prod_q  <= {32'd0, cfg.decay} * {17'd0, level_rd_q};
					state_q <= ST_EV_WR;
				end
				ST_EV_WR: begin
					max_q <= mx_next;
					sat_q <= sat_q | ev_sat;
					if (row == nn_m1_q && col == nn_m1_q) begin
						res_q       <= '{level: mx_next, saturated: sat_q | ev_sat};
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end else begin
						if (col == nn_m1_q)
							addr_q <= {row + 1'b1, {NODE_W{1'b0}}};
						else
							addr_q <= {row, col + 1'b1};
						state_q <= ST_EV_RD;
					end
				end
				ST_RD: state_q <= ST_RD_OUT;
				ST_RD_OUT: begin
					res_q       <= '{level: level_rd_q, saturated: 1'b0};
					res_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> rtl/pheromone_matrix_engine_unit.sv
// Deposit runs a 48-step divider, skipped for zero length; evaporate sweeps
// the n*n cells of the n in-use nodes; reinit fills all 4096 cells.
// Throughput: one word in the back end at a time; a two-entry command queue
// and a one-word result register keep input and output apart.
// Reset: a clearing pass fills levels and pending; full is high
// meanwhile. Depends on pme_pkg, pme_cfg, pme_front, pme_back.
`default_nettype none
module pheromone_matrix_engine_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	output logic                               full,
	input  pme_pkg::in_word_t                  item,
	output logic                               empty,
	input  wire logic                          pop,
	output pme_pkg::out_word_t                 result,
	input  wire logic                          cfg_we,
	input  wire logic [pme_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [pme_pkg::CFG_DW-1:0]    cfg_data
);
	import pme_pkg::*;

	cfg_t       cfg;
	cmd_t       cmd;
	logic       cmd_valid;
	logic       cmd_take;
	bk_status_t bk_status;

	pme_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pme_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.cfg       (cfg),
		.bk_status (bk_status),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take)
	);

	pme_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take),
		.bk_status (bk_status),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule
`default_nettype wire

>>> bench/tb_pheromone_matrix_engine_unit.sv
// Testbench for pheromone_matrix_engine_unit: directed and random words checked
// against an in-bench model of the level and pending matrices.
// Depends on pme_pkg and the RTL of the unit.
`timescale 1ns / 1ps
module tb_pheromone_matrix_engine_unit;
	import pme_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	in_word_t item = '0;
	logic empty;
	logic pop = 1'b0;
	out_word_t result;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DW-1:0] cfg_data = '0;

	pheromone_matrix_engine_unit uut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.empty(empty), .pop(pop), .result(result), .cfg_we(cfg_we),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	localparam longint LIMIT = 64'd60_000_000;

	logic [16:0] m_decay;
	logic [31:0] m_init;
	logic [6:0] m_nodes;
	logic [31:0] lvl_mat [0:4095];
	logic [31:0] pend_mat [0:4095];
	out_word_t due_q [$];
	int errors = 0;
	int n_words = 0;
	int n_checked = 0;
	longint cycles = 0;
	int stall_mode = 0;

	function automatic logic [31:0] clip(input logic [63:0] v, inout logic sat);
		if (v > 64'hFFFF_FFFF) begin
			sat = 1'b1;
			return 32'hFFFF_FFFF;
		end
		return v[31:0];
	endfunction

	function automatic out_word_t predict_update(input in_word_t w);
		out_word_t o;
		logic sat;
		int nn, ab, ba, k;
		logic [31:0] amt, v, mx;
		logic [63:0] kept;
		sat = 1'b0;
		o = '0;
		nn = (m_nodes > 7'd64) ? 64 : int'(m_nodes);
		case (mode_t'(w.mode))
			MODE_DEPOSIT: begin
				if (w.node_from < nn && w.node_to < nn) begin
					ab = w.node_from * 64 + w.node_to;
					ba = w.node_to * 64 + w.node_from;
					if (w.tour_length == 0) begin
						amt = TOP32;
						sat = 1'b1;
					end else
						amt = clip({w.deposit_scale, 16'h0} / w.tour_length, sat);
					pend_mat[ab] = clip({32'h0, pend_mat[ab]} + amt, sat);
					pend_mat[ba] = clip({32'h0, pend_mat[ba]} + amt, sat);
					o.level = amt;
				end
			end
			MODE_EVAP: begin
				mx = 0;
				for (int i = 0; i < nn; i++)
					for (int j = 0; j < nn; j++) begin
						k = i * 64 + j;
						kept = ({47'h0, m_decay} * {32'h0, lvl_mat[k]}) >> 16;
						v = clip(kept, sat);
						v = clip({32'h0, v} + pend_mat[k], sat);
						lvl_mat[k] = v;
						pend_mat[k] = 0;
						if (v > mx) mx = v;
					end
				o.level = mx;
			end
			MODE_READ: begin
				if (w.node_from < nn && w.node_to < nn)
					o.level = lvl_mat[w.node_from * 64 + w.node_to];
			end
			default: begin
				for (int i = 0; i < 4096; i++) begin
					lvl_mat[i] = m_init;
					pend_mat[i] = 0;
				end
				o.level = m_init;
			end
		endcase
		o.saturated = sat;
		return o;
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		errors++;
		if (errors <= 40)
			$display("mismatch %s: got %h want %h at word %0d", what, got, want, n_checked);
	endtask

	// sender: bursts with random gaps; push stays high inside a burst
	int burst_left = 0;
	task automatic send_word(input in_word_t w);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				push <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		item <= w;
		push <= 1'b1;
		do @(posedge clk); while (full);
		due_q.insert(due_q.size(), predict_update(w));
		n_words++;
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("timeout");
			$display("pheromone_matrix_engine_unit verification failed");
			$finish;
		end
		if (arst_n && pop && !empty) begin
			n_checked++;
			if (due_q.size() == 0)
				report("unexpected word", result.level, 32'h0);
			else begin
				if (result.level !== due_q[0].level)
					report("level", result.level, due_q[0].level);
				if (result.saturated !== due_q[0].saturated)
					report("saturated", {31'h0, result.saturated},
						{31'h0, due_q[0].saturated});
				void'(due_q.pop_front());
			end
		end
	end

	// receiver stall pattern
	int rx_phase = 0;
	always @(negedge clk) begin
		rx_phase++;
		if (rx_phase % 500 == 0) stall_mode = $urandom_range(0, 3);
		case (stall_mode)
			0: pop <= 1'b1;
			1: pop <= ($urandom_range(0, 3) != 0);
			2: pop <= (rx_phase % 7 < 3);
			default: pop <= ($urandom_range(0, 9) == 0) || (rx_phase % 40 == 0);
		endcase
	end

	task automatic drain();
		push <= 1'b0;
		while (due_q.size() != 0) @(negedge clk);
		repeat (4200) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_DECAY: m_decay = val[16:0];
			REG_INIT_LEVEL: m_init = val;
			default: m_nodes = val[6:0];
		endcase
	endtask

	function automatic in_word_t mk(input mode_t m, input int a, input int b,
			input logic [23:0] len, input logic [31:0] q);
		in_word_t w;
		w.mode = m;
		w.node_from = a[5:0];
		w.node_to = b[5:0];
		w.tour_length = len;
		w.deposit_scale = q;
		return w;
	endfunction

	task automatic test_directed();
		send_word(mk(MODE_READ, 0, 0, 24'd1, 32'd0));
		send_word(mk(MODE_READ, 63, 63, 24'hFFFFFF, 32'hFFFFFFFF));
		send_word(mk(MODE_DEPOSIT, 1, 2, 24'd3, 32'd10));
		send_word(mk(MODE_DEPOSIT, 5, 5, 24'd7, 32'd100));
		send_word(mk(MODE_DEPOSIT, 3, 4, 24'd0, 32'd1));
		send_word(mk(MODE_DEPOSIT, 6, 7, 24'd1, 32'hFFFFFFFF));
		send_word(mk(MODE_DEPOSIT, 7, 6, 24'hFFFFFF, 32'd0));
		send_word(mk(MODE_READ, 1, 2, 24'd1, 32'd0));
		send_word(mk(MODE_REINIT, 0, 0, 24'd1, 32'd0));
	endtask

	task automatic test_small_square();
		write_reg(REG_NODE_COUNT, 32'd2);
		write_reg(REG_DECAY, 32'd65536);
		send_word(mk(MODE_DEPOSIT, 0, 1, 24'd1, 32'd5));
		send_word(mk(MODE_DEPOSIT, 2, 1, 24'd1, 32'd5));
		send_word(mk(MODE_DEPOSIT, 1, 1, 24'd1, 32'hFFFF));
		send_word(mk(MODE_EVAP, 0, 0, 24'd1, 32'd0));
		send_word(mk(MODE_READ, 0, 1, 24'd1, 32'd0));
		send_word(mk(MODE_READ, 1, 1, 24'd1, 32'd0));
		send_word(mk(MODE_READ, 2, 0, 24'd1, 32'd0));
		write_reg(REG_DECAY, 32'h1FFFF);
		send_word(mk(MODE_EVAP, 0, 0, 24'd1, 32'd0));
		write_reg(REG_NODE_COUNT, 32'd0);
		send_word(mk(MODE_EVAP, 0, 0, 24'd1, 32'd0));
		write_reg(REG_NODE_COUNT, 32'd127);
		send_word(mk(MODE_READ, 63, 0, 24'd1, 32'd0));
		write_reg(REG_INIT_LEVEL, 32'hFFFFFFFF);
		send_word(mk(MODE_REINIT, 0, 0, 24'd1, 32'd0));
	endtask

	task automatic random_phase(input int count, input int nodes, input logic [16:0] dc,
			input logic [31:0] il);
		in_word_t w;
		logic [95:0] raw;
		int nn;
		write_reg(REG_NODE_COUNT, nodes);
		write_reg(REG_DECAY, {15'h0, dc});
		write_reg(REG_INIT_LEVEL, il);
		send_word(mk(MODE_REINIT, 0, 0, 24'd1, 32'd0));
		nn = (nodes > 64) ? 64 : nodes;
		for (int i = 0; i < count; i++) begin
			raw = {$urandom, $urandom, $urandom};
			w = raw[69:0];
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5, 6, 7, 8: begin
					w.mode = MODE_DEPOSIT;
					if ($urandom_range(0, 9) != 0) begin
						w.node_from = 6'($urandom_range(0, nn - 1));
						w.node_to = 6'($urandom_range(0, nn - 1));
					end
					if ($urandom_range(0, 3) != 0) w.deposit_scale = $urandom_range(0, 5000);
					if ($urandom_range(0, 2) != 0) w.tour_length = 24'($urandom_range(1, 4000));
					if ($urandom_range(0, 30) == 0) w.tour_length = '0;
				end
				9, 10, 11, 12, 13, 14, 15: begin
					w.mode = MODE_READ;
					if ($urandom_range(0, 9) != 0) begin
						w.node_from = 6'($urandom_range(0, nn - 1));
						w.node_to = 6'($urandom_range(0, nn - 1));
					end
				end
				16, 17, 18: w.mode = MODE_EVAP;
				default: w.mode = ($urandom_range(0, 3) == 0) ? MODE_REINIT : MODE_EVAP;
			endcase
			send_word(w);
		end
	endtask

	initial begin
		m_decay = DECAY_RST;
		m_init = INIT_RST;
		m_nodes = 7'd64;
		for (int i = 0; i < 4096; i++) begin
			lvl_mat[i] = INIT_RST;
			pend_mat[i] = 0;
		end
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_small_square();
		random_phase(500, 4, 17'd32768, 32'd1000);
		random_phase(500, 8, 17'd65535, 32'h10000);
		random_phase(400, 3, 17'h1FFFF, 32'hFFFF0000);
		random_phase(250, 16, 17'd0, 32'd0);
		random_phase(150, 64, 17'd58982, 32'h12345);
		drain();
		$display("covered %0d words, %0d results, all modes, node counts 0..127",
			n_words, n_checked);
		$display("decay 0 to above one, initial levels 0 to full scale");
		if (errors == 0 && due_q.size() == 0)
			$display("pheromone_matrix_engine_unit verification clean");
		else
			$display("pheromone_matrix_engine_unit verification failed");
		$finish;
	end
endmodule
